>>> rtl/bavd_pkg.sv
// ----------------------------------------------------------------------------
// Block average voltmeter package
// Shared widths, constants, types and the decimal digit split.
// ----------------------------------------------------------------------------
package bavd_pkg;

    localparam int BLOCK_LENGTH = 32;
    localparam int SAMPLE_BITS  = 12;
    localparam int COUNT_BITS   = $clog2(BLOCK_LENGTH);
    localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
    localparam int FS_BITS      = 10;
    localparam int VOLT_BITS    = 10;
    localparam int DIGIT_BITS   = 4;
    localparam int PROD_BITS    = SAMPLE_BITS + FS_BITS;
    localparam int REM_BITS     = 7;

    localparam logic [FS_BITS-1:0]    FS_RESET = FS_BITS'(330);
    localparam logic [VOLT_BITS-1:0]  VOLT_MAX = VOLT_BITS'(999);
    localparam logic [COUNT_BITS-1:0] COUNT_LAST = COUNT_BITS'(BLOCK_LENGTH - 1);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [VOLT_BITS-1:0]   volt_t;
    typedef logic [DIGIT_BITS-1:0]  digit_t;

    typedef struct packed {
        digit_t hundreds;
        digit_t tens;
        digit_t units;
    } digits_t;

    // Splits a value of at most 999 into three decimal digits by parallel
    // compares against the constant multiples of one hundred and of ten.
    function automatic digits_t split_digits(input volt_t volt);
        digits_t           d;
        logic [REM_BITS-1:0] rem_h;
        volt_t             base_h;
        logic [REM_BITS-1:0] base_t;
        d      = '0;
        base_h = '0;
        base_t = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (volt >= VOLT_BITS'(k * 100))
            begin
                d.hundreds = DIGIT_BITS'(k);
                base_h     = VOLT_BITS'(k * 100);
            end
        end
        rem_h = REM_BITS'(volt - base_h);
        for (int k = 1; k < 10; k++)
        begin
            if (rem_h >= REM_BITS'(k * 10))
            begin
                d.tens = DIGIT_BITS'(k);
                base_t = REM_BITS'(k * 10);
            end
        end
        d.units = DIGIT_BITS'(rem_h - base_t);
        return d;
    endfunction

endpackage

>>> rtl/block_average_volt_digits_top.sv
// ----------------------------------------------------------------------------
// Block average voltmeter top level
// Accumulates samples, emits the block mean, its voltage and three digits.
// ----------------------------------------------------------------------------
// Pipeline: when the last sample of a block is accepted the average stage
// loads; the result word then passes through the scaling stage and the
// digit/output stage; a stall holds each stage until the next one is free.
// Throughput: one sample word per cycle unless stalled; one result per 32 samples.
// Reset clears the count, the sum and all stage valids, and loads the full
// scale register with 330.
module block_average_volt_digits_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic [bavd_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                           full_scale_valid,
    output logic                           full_scale_ready,
    input  logic [bavd_pkg::FS_BITS-1:0]   full_scale_hundredths,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [bavd_pkg::SAMPLE_BITS-1:0] average,
    output logic [bavd_pkg::VOLT_BITS-1:0] voltage_hundredths,
    output logic [bavd_pkg::DIGIT_BITS-1:0] digit_hundreds,
    output logic [bavd_pkg::DIGIT_BITS-1:0] digit_tens,
    output logic [bavd_pkg::DIGIT_BITS-1:0] digit_units
);
    import bavd_pkg::*;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [SUM_BITS-1:0]   sum_next;
    logic [SUM_BITS-1:0]   sum_total;
    logic [FS_BITS-1:0]    fs_reg;

    logic                  avg_valid_reg;
    sample_t               avg_reg;
    logic                  volt_valid_reg;
    sample_t               volt_avg_reg;
    volt_t                 volt_reg;
    logic                  out_valid_reg;
    sample_t               out_avg_reg;
    volt_t                 out_volt_reg;
    digits_t               out_digits_reg;

    logic                  out_free;
    logic                  volt_free;
    logic                  avg_free;
    logic                  sample_take;
    logic                  block_done;
    logic [PROD_BITS-1:0]  product;
    volt_t                 volt_scaled;
    volt_t                 volt_sat;
    digits_t               digits;

    assign out_free     = !out_valid_reg || !result_stall;
    assign volt_free    = !volt_valid_reg || out_free;
    assign avg_free     = !avg_valid_reg || volt_free;
    assign sample_stall = !avg_free;
    assign sample_take  = sample_valid && avg_free;
    assign block_done   = count_reg == COUNT_LAST;

    assign full_scale_ready = 1'b1;

    always_comb
    begin
        sum_total  = sum_reg + SUM_BITS'(sample);
        sum_next   = sum_reg;
        count_next = count_reg;
        if (sample_take)
        begin
            if (block_done)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_total;
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_comb
    begin
        product     = PROD_BITS'(avg_reg) * PROD_BITS'(fs_reg);
        volt_scaled = product[PROD_BITS-1:SAMPLE_BITS];
        volt_sat    = (volt_scaled > VOLT_MAX) ? VOLT_MAX : volt_scaled;
        digits      = split_digits(volt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            sum_reg        <= '0;
            fs_reg         <= FS_RESET;
            avg_valid_reg  <= 1'b0;
            volt_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            if (full_scale_valid)
            begin
                fs_reg <= full_scale_hundredths;
            end
            if (avg_free)
            begin
                avg_valid_reg <= sample_take && block_done;
            end
            if (volt_free)
            begin
                volt_valid_reg <= avg_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= volt_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take && block_done)
        begin
            avg_reg <= sum_total[SUM_BITS-1:COUNT_BITS];
        end
        if (volt_free && avg_valid_reg)
        begin
            volt_avg_reg <= avg_reg;
            volt_reg     <= volt_sat;
        end
        if (out_free && volt_valid_reg)
        begin
            out_avg_reg    <= volt_avg_reg;
            out_volt_reg   <= volt_reg;
            out_digits_reg <= digits;
        end
    end

    assign result_valid       = out_valid_reg;
    assign average            = out_avg_reg;
    assign voltage_hundredths = out_volt_reg;
    assign digit_hundreds     = out_digits_reg.hundreds;
    assign digit_tens         = out_digits_reg.tens;
    assign digit_units        = out_digits_reg.units;

    a_block_end_starts_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_take && block_done) |=> (avg_valid_reg && count_reg == '0 && sum_reg == '0))
    else $error("Block end did not load the average stage and clear the accumulator.");

    a_volt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (voltage_hundredths <= VOLT_MAX))
    else $error("Voltage exceeds the saturation limit.");

    a_digits_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (VOLT_BITS'(digit_hundreds) * VOLT_BITS'(100)
            + VOLT_BITS'(digit_tens) * VOLT_BITS'(10)
            + VOLT_BITS'(digit_units) == voltage_hundredths))
    else $error("Decimal digits do not match the voltage.");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (avg_valid_reg && !volt_free) |=> (avg_valid_reg && $stable(avg_reg)))
    else $error("Average stage was overwritten while blocked.");

endmodule
